@@ sv/md5_pkg.sv @@
package md5_pkg;

    localparam int BUF_BYTES  = 64;
    localparam int BYTE_LANES = 4;
    localparam int BUF_WORDS  = BUF_BYTES / BYTE_LANES;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'h3F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } t_md5_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_md5_out;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_work;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_phase;

    localparam logic [31:0] MD5_K [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // message word used by a step
    function automatic logic [3:0] md5_msg_index(input logic [5:0] step);
        logic [3:0] s;
        logic [3:0] g;
        s = step[3:0];
        unique case (step[5:4])
            2'd0: g = s;
            2'd1: g = (s << 2) + s + 4'd1;
            2'd2: g = (s << 1) + s + 4'd5;
            2'd3: g = (s << 3) - s;
            default: g = s;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] step);
        logic [4:0] r;
        unique case ({step[5:4], step[1:0]})
            4'h0: r = 5'd7;
            4'h1: r = 5'd12;
            4'h2: r = 5'd17;
            4'h3: r = 5'd22;
            4'h4: r = 5'd5;
            4'h5: r = 5'd9;
            4'h6: r = 5'd14;
            4'h7: r = 5'd20;
            4'h8: r = 5'd4;
            4'h9: r = 5'd11;
            4'hA: r = 5'd16;
            4'hB: r = 5'd23;
            4'hC: r = 5'd6;
            4'hD: r = 5'd10;
            4'hE: r = 5'd15;
            4'hF: r = 5'd21;
            default: r = 5'd7;
        endcase
        return r;
    endfunction

endpackage

@@ sv/md5_message_digest.sv @@
// Bytes are taken one per cycle while the block buffer fills; the byte that completes
// a 64-byte block stalls input through the 64 compression steps (one step per cycle,
// behind the buffer RAM's read latency) and the chaining-word add.
// A message end writes 9 to 72 pad bytes, runs one or two compressions,
// then gives four digest words, one per cycle while i_out_stall is low. Reset (i_rst_n low,
// synchronous) loads the IV and clears the bit count; the buffer RAM is not cleared.
module md5_message_digest (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  md5_pkg::t_md5_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output md5_pkg::t_md5_out o_out_data
);
    import md5_pkg::*;

    localparam int AW = $clog2(BUF_WORDS);

    t_state      r_state;
    t_state      n_state;
    t_state      r_after;
    t_phase      r_phase;
    logic [5:0]  r_pos;
    logic [63:0] r_bit_count;
    logic [63:0] r_len;
    logic [31:0] r_chain [4];
    logic [1:0]  r_out_idx;
    logic [6:0]  r_cnt;
    t_work       r_work;
    t_work       step_work;

    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   msg_word;
    logic [5:0]    step_idx;
    logic          pos_wrap;
    logic [5:0]    pos_inc;

    assign pos_inc  = r_pos + 6'd1;
    assign pos_wrap = ram_we && (r_pos == LAST_POS);
    assign step_idx = r_cnt[5:0] - 6'd1;
    assign ram_raddr = md5_msg_index(r_cnt[5:0]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (pos_wrap) begin
                        n_state = ST_COMP;
                    end else if (i_in_data.message_end) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pos_wrap) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (r_cnt[6]) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: n_state = r_after;
            ST_OUT: begin
                if (!i_out_stall && r_out_idx == 2'd3) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and buffer write port
    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = i_in_data.data_byte;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                ram_we     = i_in_valid && i_in_data.byte_valid;
            end
            ST_PAD: begin
                ram_we = 1'b1;
                unique case (r_phase)
                    PH_MARK: ram_wdata = PAD_MARK;
                    PH_ZERO: ram_wdata = '0;
                    PH_LEN:  ram_wdata = r_len[{r_pos[2:0], 3'b000} +: 8];
                    default: ram_wdata = '0;
                endcase
            end
            ST_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_out_data.digest_word = r_chain[r_out_idx];
    assign o_out_data.word_index  = r_out_idx;
    assign o_out_data.last_word   = (r_out_idx == 2'd3);

    for (genvar lane = 0; lane < BYTE_LANES; lane++) begin : g_lane
        md5_ram #(
            .WIDTH(8),
            .DEPTH(BUF_WORDS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (ram_we && (r_pos[1:0] == 2'(lane))),
            .i_waddr(r_pos[5:2]),
            .i_wdata(ram_wdata),
            .i_raddr(ram_raddr),
            .o_rdata(msg_word[8*lane +: 8])
        );
    end

    md5_step u_step (
        .i_work(r_work),
        .i_m   (msg_word),
        .i_step(step_idx),
        .o_work(step_work)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_after     <= ST_IDLE;
            r_phase     <= PH_MARK;
            r_pos       <= '0;
            r_bit_count <= '0;
            r_out_idx   <= '0;
            r_cnt       <= '0;
            r_chain[0]  <= IV_A;
            r_chain[1]  <= IV_B;
            r_chain[2]  <= IV_C;
            r_chain[3]  <= IV_D;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_pos <= pos_inc;
            end
            if (pos_wrap) begin
                r_cnt <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.message_end) begin
                            r_bit_count <= '0;
                            r_phase     <= PH_MARK;
                        end else if (i_in_data.byte_valid) begin
                            r_bit_count <= r_bit_count + 64'd8;
                        end
                        r_after <= i_in_data.message_end ? ST_PAD : ST_IDLE;
                    end
                end
                ST_PAD: begin
                    if (r_phase != PH_LEN) begin
                        r_phase <= (pos_inc == LEN_POS) ? PH_LEN : PH_ZERO;
                    end
                    r_after <= (r_phase == PH_LEN) ? ST_OUT : ST_PAD;
                end
                ST_COMP: r_cnt <= r_cnt + 7'd1;
                ST_FIN: begin
                    r_chain[0] <= r_chain[0] + r_work.a;
                    r_chain[1] <= r_chain[1] + r_work.b;
                    r_chain[2] <= r_chain[2] + r_work.c;
                    r_chain[3] <= r_chain[3] + r_work.d;
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_out_idx <= r_out_idx + 2'd1;
                        if (r_out_idx == 2'd3) begin
                            r_chain[0] <= IV_A;
                            r_chain[1] <= IV_B;
                            r_chain[2] <= IV_C;
                            r_chain[3] <= IV_D;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // working variables and latched length
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid && i_in_data.message_end) begin
            r_len <= r_bit_count + (i_in_data.byte_valid ? 64'd8 : 64'd0);
        end
        if (pos_wrap) begin
            r_work <= '{a: r_chain[0], b: r_chain[1], c: r_chain[2], d: r_chain[3]};
        end else if (r_state == ST_COMP && r_cnt != 7'd0) begin
            r_work <= step_work;
        end
    end

endmodule

@@ sv/md5_ram.sv @@
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/md5_step.sv @@
module md5_step (
    input  md5_pkg::t_work i_work,
    input  logic [31:0]    i_m,
    input  logic [5:0]     i_step,
    output md5_pkg::t_work o_work
);
    import md5_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  rot;
    logic [63:0] rot_dbl;

    always_comb begin
        unique case (i_step[5:4])
            2'd0: f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            2'd1: f = (i_work.b & i_work.d) | (i_work.c & ~i_work.d);
            2'd2: f = i_work.b ^ i_work.c ^ i_work.d;
            2'd3: f = i_work.c ^ (i_work.b | ~i_work.d);
            default: f = '0;
        endcase
    end

    assign sum     = i_work.a + f + MD5_K[i_step] + i_m;
    assign rot     = md5_rot(i_step);
    assign rot_dbl = {sum, sum} << rot;

    assign o_work.a = i_work.d;
    assign o_work.b = i_work.b + rot_dbl[63:32];
    assign o_work.c = i_work.b;
    assign o_work.d = i_work.c;

endmodule

@@ sv/md5_chk.sv @@
module md5_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input md5_pkg::t_md5_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input md5_pkg::t_md5_out o_out_data
);

    // no input transfer while the digest is being delivered
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during digest output");

    // input stalls right after a message-end transfer (padding or a compression follows)
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.message_end) |=> o_in_stall)
        else $error("input open right after message end");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_word == (o_out_data.word_index == 2'd3)))
        else $error("last_word does not match word_index");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_word) |=>
        (o_out_valid &&
         o_out_data.word_index == 2'($past(o_out_data.word_index) + 2'd1)))
        else $error("digest words out of sequence");

    a_digest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_word) |=> !o_out_valid)
        else $error("extra digest word after the last one");

endmodule

bind md5_message_digest md5_chk u_md5_chk (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import md5_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // lengths around the padding and block boundaries
    localparam int EDGE_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    class digest_scoreboard;
        logic [31:0] chain_word [4];
        logic [7:0]  block_bytes [64];
        logic [63:0] message_bits;
        t_md5_out    digest_due [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain_word[0] = 32'h67452301;
            chain_word[1] = 32'hEFCDAB89;
            chain_word[2] = 32'h98BADCFE;
            chain_word[3] = 32'h10325476;
            message_bits  = '0;
        endfunction

        function logic [31:0] rotl(input logic [31:0] x, input int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] m [16];
            logic [31:0] a, b, c, d, f, t;
            int g;
            int r;
            for (int i = 0; i < 16; i++) begin
                m[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                        block_bytes[4*i+1], block_bytes[4*i]};
            end
            a = chain_word[0];
            b = chain_word[1];
            c = chain_word[2];
            d = chain_word[3];
            for (int i = 0; i < 64; i++) begin
                r = i / 16;
                case (r)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = (5 * i + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                t = a + f + SINE_K[i] + m[g];
                a = d;
                d = c;
                c = b;
                b = b + rotl(t, ROT_AMT[r * 4 + i % 4]);
            end
            chain_word[0] += a;
            chain_word[1] += b;
            chain_word[2] += c;
            chain_word[3] += d;
        endfunction

        function void put_byte(input logic [7:0] v, inout logic [5:0] pos);
            block_bytes[pos] = v;
            pos = pos + 6'd1;
            if (pos == 6'd0) compress();
        endfunction

        function int pending();
            return digest_due.size();
        endfunction

        function void note_transfer(input t_md5_in x);
            logic [5:0]  pos;
            logic [63:0] len;
            t_md5_out    w;
            pos = message_bits[8:3];
            if (x.byte_valid) begin
                put_byte(x.data_byte, pos);
                message_bits += 64'd8;
            end
            if (!x.message_end) return;
            len = message_bits;
            put_byte(8'h80, pos);
            while (pos != 6'd56) put_byte(8'h00, pos);
            for (int k = 0; k < 8; k++) put_byte(len[8*k +: 8], pos);
            for (int k = 0; k < 4; k++) begin
                w.digest_word = chain_word[k];
                w.word_index  = 2'(k);
                w.last_word   = (k == 3);
                digest_due.push_back(w);
            end
            restart();
        endfunction

        task report(input string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(input t_md5_out got);
            t_md5_out want;
            if (digest_due.size() == 0) begin
                report($sformatf("unexpected digest word %h", got.digest_word));
                return;
            end
            want = digest_due.pop_front();
            if (got.digest_word !== want.digest_word)
                report($sformatf("digest_word %h, want %h", got.digest_word, want.digest_word));
            if (got.word_index !== want.word_index)
                report($sformatf("word_index %0d, want %0d", got.word_index, want.word_index));
            if (got.last_word !== want.last_word)
                report($sformatf("last_word %b, want %b", got.last_word, want.last_word));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_md5_in  in_data;
    logic     out_valid;
    logic     out_stall;
    t_md5_out out_data;

    digest_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 1'b0;
    int  item_count = 0;

    md5_message_digest i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int idle_draw();
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic t_md5_in make_item(input logic [7:0] d, input logic v, input logic e);
        t_md5_in x;
        x.data_byte   = d;
        x.byte_valid  = v;
        x.message_end = e;
        return x;
    endfunction

    task automatic send_item(input t_md5_in x);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge clk); while (in_stall);
        sb.note_transfer(x);
        if (x.byte_valid || x.message_end) item_count++;
    endtask

    // the sender goes idle so the last transfer is not repeated
    task automatic wait_for_digests();
        if (sb.pending() != 0) in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // message of len random bytes, with stray idle transfers mixed in
    task automatic send_message(input int len);
        bit merge_end;
        merge_end = (len > 0) && $urandom_range(0, 1);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(make_item(8'($urandom), 1'b0, 1'b0));
            send_item(make_item(8'($urandom), 1'b1, merge_end && (k == len - 1)));
        end
        if (!merge_end)
            send_item(make_item(8'($urandom), 1'b0, 1'b1));
    endtask

    // result side
    initial begin
        int gap;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = idle_draw();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial begin
        int len;
        in_valid <= 1'b0;
        in_data  <= '0;
        rst_n    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, idle transfer, byte with end, empty final transfer
        calm = 1'b1;
        send_item(make_item(8'h00, 1'b0, 1'b1));
        send_item(make_item(8'hFF, 1'b0, 1'b0));
        send_item(make_item(8'h61, 1'b1, 1'b1));
        calm = 1'b0;
        send_item(make_item(8'h00, 1'b1, 1'b0));
        send_item(make_item(8'hFF, 1'b1, 1'b0));
        send_item(make_item(8'h00, 1'b0, 1'b1));
        send_item(make_item(8'hFF, 1'b0, 1'b1));
        send_item(make_item(8'hFF, 1'b1, 1'b1));
        send_item(make_item(8'h55, 1'b1, 1'b0));
        send_item(make_item(8'hAA, 1'b1, 1'b1));
        wait_for_digests();

        // random messages, weighted toward the padding boundaries
        while (item_count < 100) begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: len = $urandom_range(0, 12);
                10, 11, 12, 13, 14, 15, 16: len = EDGE_LEN[$urandom_range(0, 8)];
                default: len = $urandom_range(0, 130);
            endcase
            // keep the total near the item budget
            if (len > 100 - item_count) len = 100 - item_count;
            send_message(len);
            if ($urandom_range(0, 5) == 0) wait_for_digests();
        end

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
